/* design/assert_macros.svh */
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* design/crpt_pkg.sv */
package crpt_pkg;

    localparam int CP_W = 21;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic [1:0]      cmd;
        logic [CP_W-1:0] range_low;
        logic [CP_W-1:0] range_high;
        logic [5:0]      entry_index;
    } req_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [5:0]      class_index;
        logic [CP_W-1:0] entry_low;
        logic [CP_W-1:0] entry_high;
        logic [6:0]      entry_count;
    } rsp_t;

    typedef struct packed {
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
    } range_t;

endpackage

/* design/crpt_mem.sv */
module crpt_mem
    import crpt_pkg::*;
#(
    parameter int AW = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  range_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output range_t        rdata
);

    range_t mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/char_range_partition_table.sv */
// Character-class range partition table.
// Command channel: a transaction is taken on a rising edge with start high and
// busy low; request carries cmd, range bounds and entry index. The result
// appears on result with done high for exactly one cycle; it cannot be held.
// Clear, reversed inserts and bad-index reads end in S_TRIV; a read passes
// S_RD_ISSUE, S_RD_WAIT. Lookup is a binary search; a probe is S_LK_RD, S_LK_CMP.
// Insert streams the table through the memory's single read port, spending
// one phase per possible output piece on each stored range, then passes
// S_INS_TAIL and S_INS_END; an empty table goes straight to S_INS_TAIL. The
// new table is written into the other half of a double-buffered memory and
// swapped in only if it fits, so an overflowing insert walks the whole table
// and leaves the old table untouched.
// Only one transaction is in flight; busy stays high until its result shows.
// Reset empties the table at once; no clearing pass is needed.
module char_range_partition_table
    import crpt_pkg::*;
#(
    parameter int MAX_RANGES = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

`include "assert_macros.svh"

    localparam int AW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 2);
    localparam logic [CW-1:0] MAXC = CW'(MAX_RANGES);

    typedef enum logic [3:0] {
        S_IDLE, S_TRIV, S_INS_RD, S_INS_PC, S_INS_TAIL, S_INS_END,
        S_LK_RD, S_LK_CMP, S_RD_ISSUE, S_RD_WAIT
    } state_t;

    state_t          state_reg;
    req_t            req_reg;
    logic [1:0]      status_reg;
    logic [CW-1:0]   used_reg;
    logic            act_reg;
    logic [CW-1:0]   i_reg;
    logic [1:0]      ph_reg;
    logic [CW-1:0]   cnt_reg;
    logic [CP_W-1:0] cur_reg;
    logic            pend_reg;
    logic [CW-1:0]   l_reg;
    logic [CW-1:0]   h_reg;
    logic [CW-1:0]   m_reg;
    logic            done_reg;
    rsp_t            result_reg;

    range_t          rdata;
    logic            re, we;
    logic [AW:0]     raddr, waddr;
    range_t          wdata;

    logic [CP_W-1:0] s, e, lo, hi;
    logic            ov, more;
    logic            pc_valid;
    range_t          pc;
    logic [CW:0]     msum;
    logic [CW-1:0]   m_next;
    logic [CW-1:0]   cnt_next;
    logic            idx_ok;

    assign s  = rdata.lo;
    assign e  = rdata.hi;
    assign lo = req_reg.range_low;
    assign hi = req_reg.range_high;
    assign ov = !(e < lo || s > hi);
    assign more = ({1'b0, i_reg} + (CW+1)'(1)) < {1'b0, used_reg};
    assign msum = ({1'b0, l_reg} + {1'b0, h_reg}) >> 1;
    assign m_next = msum[CW-1:0];
    assign cnt_next = (cnt_reg > MAXC) ? cnt_reg : cnt_reg + CW'(1);
    assign idx_ok = ({{CW{1'b0}}, request.entry_index} < {6'd0, used_reg});

    // Piece emitted in the current phase of the insert walk
    always_comb
    begin
        pc_valid = 1'b0;
        pc.lo = s;
        pc.hi = e;
        case (ph_reg)
            2'd0:
            begin
                pc_valid = pend_reg && (s > cur_reg);
                pc.lo = cur_reg;
                pc.hi = (s > hi) ? hi : s - CP_W'(1);
            end
            2'd1:
            begin
                if (!ov)
                begin
                    pc_valid = 1'b1;
                end
                else if (s < lo)
                begin
                    pc_valid = 1'b1;
                    pc.hi = lo - CP_W'(1);
                end
            end
            2'd2:
            begin
                pc_valid = ov;
                pc.lo = (s > lo) ? s : lo;
                pc.hi = (e < hi) ? e : hi;
            end
            default:
            begin
                pc_valid = ov && (e > hi);
                pc.lo = hi + CP_W'(1);
            end
        endcase
    end

    always_comb
    begin
        re = 1'b0;
        raddr = {act_reg, i_reg[AW-1:0]};
        we = 1'b0;
        waddr = {~act_reg, cnt_reg[AW-1:0]};
        wdata = pc;
        case (state_reg)
            S_INS_RD:
            begin
                re = 1'b1;
            end
            S_INS_PC:
            begin
                we = pc_valid && (cnt_reg < MAXC);
                if (ph_reg == 2'd3 && more)
                begin
                    re = 1'b1;
                    raddr = {act_reg, AW'(i_reg + CW'(1))};
                end
            end
            S_INS_TAIL:
            begin
                we = pend_reg && (cnt_reg < MAXC);
                wdata.lo = cur_reg;
                wdata.hi = hi;
            end
            S_LK_RD:
            begin
                re = 1'b1;
                raddr = {act_reg, m_next[AW-1:0]};
            end
            S_RD_ISSUE:
            begin
                re = 1'b1;
                raddr = {act_reg, AW'(req_reg.entry_index)};
            end
            default:
            begin
                re = 1'b0;
            end
        endcase
    end

    crpt_mem #(.AW(AW + 1)) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            req_reg    <= '0;
            used_reg   <= '0;
            act_reg    <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
            i_reg      <= '0;
            ph_reg     <= '0;
            cnt_reg    <= '0;
            cur_reg    <= '0;
            pend_reg   <= 1'b0;
            l_reg      <= '0;
            h_reg      <= '0;
            m_reg      <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg    <= request;
                        status_reg <= ST_OK;
                        i_reg      <= '0;
                        ph_reg     <= '0;
                        cnt_reg    <= '0;
                        cur_reg    <= request.range_low;
                        pend_reg   <= 1'b1;
                        l_reg      <= '0;
                        h_reg      <= used_reg;
                        state_reg  <= S_TRIV;
                        case (request.cmd)
                            CMD_CLEAR:
                            begin
                                used_reg <= '0;
                            end
                            CMD_INSERT:
                            begin
                                if (request.range_low <= request.range_high)
                                begin
                                    state_reg <= (used_reg == '0) ? S_INS_TAIL : S_INS_RD;
                                end
                            end
                            CMD_LOOKUP:
                            begin
                                state_reg <= S_LK_RD;
                            end
                            default:
                            begin
                                if (idx_ok)
                                begin
                                    state_reg <= S_RD_ISSUE;
                                end
                                else
                                begin
                                    status_reg <= ST_BAD_INDEX;
                                end
                            end
                        endcase
                    end
                end
                S_TRIV:
                begin
                    result_reg <= '{status: status_reg, class_index: '0, entry_low: '0,
                                    entry_high: '0, entry_count: 7'(used_reg)};
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_INS_RD:
                begin
                    state_reg <= S_INS_PC;
                end
                S_INS_PC:
                begin
                    if (pc_valid)
                    begin
                        cnt_reg <= cnt_next;
                    end
                    if (ph_reg == 2'd0 && pend_reg && s > cur_reg && s > hi)
                    begin
                        pend_reg <= 1'b0;
                    end
                    ph_reg <= ph_reg + 2'd1;
                    if (ph_reg == 2'd3)
                    begin
                        // close out this stored range and advance the uncovered cursor
                        if (ov && pend_reg)
                        begin
                            if (e >= hi)
                            begin
                                pend_reg <= 1'b0;
                            end
                            else
                            begin
                                cur_reg <= e + CP_W'(1);
                            end
                        end
                        if (more)
                        begin
                            i_reg <= i_reg + CW'(1);
                        end
                        else
                        begin
                            state_reg <= S_INS_TAIL;
                        end
                    end
                end
                S_INS_TAIL:
                begin
                    if (pend_reg)
                    begin
                        cnt_reg <= cnt_next;
                    end
                    state_reg <= S_INS_END;
                end
                S_INS_END:
                begin
                    if (cnt_reg > MAXC)
                    begin
                        result_reg <= '{status: ST_FULL, class_index: '0, entry_low: '0,
                                        entry_high: '0, entry_count: 7'(used_reg)};
                    end
                    else
                    begin
                        act_reg  <= ~act_reg;
                        used_reg <= cnt_reg;
                        result_reg <= '{status: ST_OK, class_index: '0, entry_low: '0,
                                        entry_high: '0, entry_count: 7'(cnt_reg)};
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_LK_RD:
                begin
                    if (l_reg >= h_reg)
                    begin
                        result_reg <= '{status: ST_NOT_FOUND, class_index: '0,
                                        entry_low: '0, entry_high: '0,
                                        entry_count: 7'(used_reg)};
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        m_reg     <= m_next;
                        state_reg <= S_LK_CMP;
                    end
                end
                S_LK_CMP:
                begin
                    if (lo < s)
                    begin
                        h_reg     <= m_reg;
                        state_reg <= S_LK_RD;
                    end
                    else if (lo > e)
                    begin
                        l_reg     <= m_reg + CW'(1);
                        state_reg <= S_LK_RD;
                    end
                    else
                    begin
                        result_reg <= '{status: ST_OK, class_index: 6'(m_reg),
                                        entry_low: '0, entry_high: '0,
                                        entry_count: 7'(used_reg)};
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_RD_ISSUE:
                begin
                    state_reg <= S_RD_WAIT;
                end
                S_RD_WAIT:
                begin
                    result_reg <= '{status: ST_OK, class_index: '0, entry_low: s,
                                    entry_high: e, entry_count: 7'(used_reg)};
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_PROP(a_done_idle, clk, rst_n, done |-> !busy)
    `ASSERT_PROP(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
    `ASSERT_PROP(a_done_after_busy, clk, rst_n, done |-> $past(busy))
    `ASSERT_NEVER(a_used_bound, clk, rst_n, used_reg > MAXC)
    `ASSERT_NEVER(a_write_bound, clk, rst_n, we && (cnt_reg >= MAXC))

endmodule
